// ===== hw/rtl/wfrm_pkg.sv =====
// Shared constants for the windowed frame rate meter.
`default_nettype none
package wfrm_pkg;
	localparam int FRAME_TIME_W        = 24;
	localparam int RATE_W              = 26;
	localparam int WSIZE_W             = 8;
	localparam int MAX_WINDOW_DEF      = 128;
	localparam int RECALC_INTERVAL_DEF = 30;
	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 8'd120;
	// 1000 ms/s in Q8, times the Q8 of the input: 1000 * 2^16
	localparam logic [RATE_W-1:0] RATE_SCALE = 26'd65536000;
	localparam logic [RATE_W-1:0] RATE_MAX   = {RATE_W{1'b1}};
endpackage
`default_nettype wire

// ===== hw/rtl/wfrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wfrm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/windowed_frame_rate_meter_top.sv =====
// Windowed frame rate meter: sample ring, running sum and serial divider.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------
//  in      | in  | in_valid / in_stall    | frame_time (Q16.8 ms)
//  out     | out | out_valid / out_stall  | frame_rate (Q18.8 fps), rate_updated
//  cfg     | in  | cfg_wr_en              | cfg_wr_data (window_size)
//
// A plain sample passes through accept, ring read/update and result.
// A recompute request adds a prepare step, then, unless the sum is zero,
// the restoring divider that retires one quotient bit per cycle, and a finish step.
// in_stall is high from accept until the result has been taken.
// Reset clears sum, fill, pointer, phase and held rate; window_size = 120.
// The ring RAM is not cleared: the fill count keeps unwritten slots unread.
`default_nettype none
module windowed_frame_rate_meter_top #(
	parameter int MAX_WINDOW      = wfrm_pkg::MAX_WINDOW_DEF,
	parameter int RECALC_INTERVAL = wfrm_pkg::RECALC_INTERVAL_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [wfrm_pkg::WSIZE_W-1:0]      cfg_wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [wfrm_pkg::FRAME_TIME_W-1:0] frame_time,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [wfrm_pkg::RATE_W-1:0]       frame_rate,
	output logic                                   rate_updated
);
	import wfrm_pkg::*;

	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int FILL_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = FRAME_TIME_W + PTR_W;
	localparam int CMP_W  = (FILL_W > WSIZE_W) ? FILL_W : WSIZE_W;
	localparam int PH_W   = $clog2(RECALC_INTERVAL + 1);
	// numerator RATE_SCALE * fill, quotient computed at full width then clipped
	localparam int NUM_W  = RATE_W + FILL_W;
	localparam int CNT_W  = $clog2(NUM_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PREP,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic [WSIZE_W-1:0]      wsize_q;
	logic [SUM_W-1:0]        sum_q;
	logic [FILL_W-1:0]       fill_q;
	logic [PTR_W-1:0]        wp_q;
	logic [PTR_W-1:0]        slot_q;
	logic [PH_W-1:0]         phase_q;
	logic [RATE_W-1:0]       held_q;
	logic                    upd_q;
	logic [FRAME_TIME_W-1:0] sample_q;
	logic [NUM_W-1:0]        num_q;
	logic [SUM_W:0]          rem_q;
	logic [CNT_W-1:0]        cnt_q;

	logic                    in_acc;
	logic [FILL_W-1:0]       w_eff;
	logic [CMP_W-1:0]        ws_ext;
	logic [PTR_W-1:0]        slot;
	logic [FILL_W-1:0]       slot_inc;
	logic [FRAME_TIME_W-1:0] old_sample;
	logic                    full;
	logic [SUM_W-1:0]        sum_next;
	logic [PH_W-1:0]         phase_inc;
	logic [SUM_W:0]          rem_sh;
	logic [SUM_W+1:0]        rem_diff;
	logic                    qbit;

	// effective window: zero reads as 1, clipped at MAX_WINDOW
	always_comb begin
		ws_ext = CMP_W'(wsize_q);
		if (ws_ext == '0) begin
			w_eff = FILL_W'(1);
		end else if (ws_ext > CMP_W'(MAX_WINDOW)) begin
			w_eff = FILL_W'(MAX_WINDOW);
		end else begin
			w_eff = FILL_W'(ws_ext);
		end
	end

	assign in_acc = in_valid && !in_stall;
	assign slot   = (FILL_W'(wp_q) >= w_eff) ? '0 : wp_q;

	// ring update done in ST_READ, old sample arrives from the RAM there
	assign full      = (fill_q >= w_eff);
	assign slot_inc  = FILL_W'(slot_q) + FILL_W'(1);
	assign sum_next  = sum_q - (full ? SUM_W'(old_sample) : '0) + SUM_W'(sample_q);
	assign phase_inc = phase_q + PH_W'(1);

	// one restoring division step
	assign rem_sh   = {rem_q[SUM_W-1:0], num_q[NUM_W-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, sum_q};
	assign qbit     = !rem_diff[SUM_W+1];

	wfrm_ram #(
		.WIDTH(FRAME_TIME_W),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (state_q == ST_READ),
		.waddr(slot_q),
		.wdata(sample_q),
		.re   (in_acc),
		.raddr(slot),
		.rdata(old_sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wsize_q <= WSIZE_RESET;
			sum_q   <= '0;
			fill_q  <= '0;
			wp_q    <= '0;
			phase_q <= '0;
			held_q  <= '0;
			upd_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sample_q <= frame_time;
						slot_q   <= slot;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					sum_q <= sum_next;
					if (!full) begin
						fill_q <= fill_q + FILL_W'(1);
					end
					wp_q <= (slot_inc >= w_eff) ? '0 : PTR_W'(slot_inc);
					if (phase_inc >= PH_W'(RECALC_INTERVAL)) begin
						phase_q <= '0;
						upd_q   <= 1'b1;
						state_q <= ST_PREP;
					end else begin
						phase_q <= phase_inc;
						upd_q   <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_PREP: begin
					if (sum_q == '0) begin
						held_q  <= '0;
						state_q <= ST_OUT;
					end else begin
						num_q   <= NUM_W'(RATE_SCALE) * NUM_W'(fill_q);
						rem_q   <= '0;
						cnt_q   <= CNT_W'(NUM_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					num_q <= {num_q[NUM_W-2:0], qbit};
					if (qbit) begin
						rem_q <= rem_diff[SUM_W:0];
					end else begin
						rem_q <= rem_sh;
					end
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_FIN: begin
					held_q  <= (|num_q[NUM_W-1:RATE_W]) ? RATE_MAX : num_q[RATE_W-1:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// window_size write clears the window (the user must write it only while the block is idle; not enforced here)
			if (cfg_wr_en) begin
				wsize_q <= cfg_wr_data;
				sum_q   <= '0;
				fill_q  <= '0;
				wp_q    <= '0;
			end
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = (state_q == ST_OUT);
	assign frame_rate   = held_q;
	assign rate_updated = upd_q;

	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= w_eff)
		else $error("fill count exceeds window");

	a_wp_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		FILL_W'(wp_q) < w_eff)
		else $error("write pointer outside window");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	a_update_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rate_updated) |-> (phase_q == '0))
		else $error("recompute reported off phase");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (sum_q != '0))
		else $error("division by zero sum");
endmodule
`default_nettype wire

// ===== tb/sv/frame_rate_checker.sv =====
// Port monitor for the frame rate meter: predicts every rate report and compares it.
module frame_rate_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [wfrm_pkg::WSIZE_W-1:0]      cfg_wr_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [wfrm_pkg::FRAME_TIME_W-1:0] frame_time,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [wfrm_pkg::RATE_W-1:0]       frame_rate,
	input  logic                              rate_updated,
	output int                                mismatches,
	output int                                outstanding,
	output int                                reports,
	output int                                refreshes,
	output int                                saturated,
	output int                                zeroed
);
	import wfrm_pkg::*;

	localparam int PTR_W   = $clog2(MAX_WINDOW_DEF);
	localparam int PHASE_W = $clog2(RECALC_INTERVAL_DEF + 1);

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              updated;
	} rate_report_t;

	// mirrored meter state
	logic [FRAME_TIME_W-1:0] ring [MAX_WINDOW_DEF];
	logic [31:0]             sum;
	logic [7:0]              fill;
	logic [PTR_W-1:0]        wptr;
	logic [PHASE_W-1:0]      phase;
	logic [RATE_W-1:0]       held;
	logic [WSIZE_W-1:0]      wsize;

	rate_report_t rate_due[$];
	rate_report_t want;
	int n_bad, n_seen, n_refresh, n_sat, n_zero;

	// zero acts as one, oversize clamps to the ring depth
	function automatic int unsigned span();
		if (wsize == '0)
			return 1;
		if (wsize > MAX_WINDOW_DEF)
			return MAX_WINDOW_DEF;
		return wsize;
	endfunction

	function automatic rate_report_t advance_window(logic [FRAME_TIME_W-1:0] ft);
		int unsigned       w;
		int unsigned       slot;
		longint unsigned   q;
		rate_report_t      r;
		w = span();
		slot = wptr;
		if (slot >= w)
			slot = 0;
		if (fill >= w)
			sum = sum - 32'(ring[slot]);
		else
			fill = fill + 8'd1;
		ring[slot] = ft;
		sum = sum + 32'(ft);
		slot++;
		wptr = PTR_W'((slot >= w) ? 0 : slot);
		r.updated = 1'b0;
		phase = phase + 1'b1;
		if (phase >= RECALC_INTERVAL_DEF) begin
			phase = '0;
			r.updated = 1'b1;
			n_refresh++;
			if (sum == 0) begin
				held = '0;
				n_zero++;
			end else begin
				q = (64'(RATE_SCALE) * 64'(fill)) / 64'(sum);
				if (q > 64'(RATE_MAX)) begin
					held = RATE_MAX;
					n_sat++;
				end else begin
					held = RATE_W'(q);
				end
			end
		end
		r.rate = held;
		return r;
	endfunction

	initial begin
		n_bad = 0;
		n_seen = 0;
		n_refresh = 0;
		n_sat = 0;
		n_zero = 0;
		mismatches = 0;
		outstanding = 0;
		reports = 0;
		refreshes = 0;
		saturated = 0;
		zeroed = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize = WSIZE_RESET;
			sum = '0;
			fill = '0;
			wptr = '0;
			phase = '0;
			held = '0;
			rate_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				wsize = cfg_wr_data;
				sum = '0;
				fill = '0;
				wptr = '0;
			end
			if (in_valid && !in_stall)
				rate_due.insert(rate_due.size(), advance_window(frame_time));
			if (out_valid && !out_stall) begin
				if (rate_due.size() == 0) begin
					n_bad++;
					$error("unexpected rate report: frame_rate %0d rate_updated %0d",
						frame_rate, rate_updated);
				end else begin
					want = rate_due[0];
					rate_due.delete(0);
					n_seen++;
					if (frame_rate !== want.rate) begin
						n_bad++;
						$error("frame_rate: expected %0d, actual %0d", want.rate, frame_rate);
					end
					if (rate_updated !== want.updated) begin
						n_bad++;
						$error("rate_updated: expected %0d, actual %0d",
							want.updated, rate_updated);
					end
				end
			end
			outstanding <= rate_due.size();
			mismatches <= n_bad;
			reports <= n_seen;
			refreshes <= n_refresh;
			saturated <= n_sat;
			zeroed <= n_zero;
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the frame rate meter bench: clock, reset, stimulus, verdict.
module testbench;
	import wfrm_pkg::*;

	localparam int TOTAL_ITEMS = 1450;
	localparam int CALM_TAIL   = 150;     // last requests go with no idling
	localparam int HOLDOFF     = 400;     // long receiver hold-off, in cycles
	localparam int DRAIN       = 60;      // margin for anything stray after the last report
	localparam int CYCLE_LIMIT = 600000;

	// content of one phase of random requests
	typedef enum int {
		ST_ZERO,      // all zero: window sum stays zero
		ST_TINY,      // 0 or 1: rate saturates once the window holds several
		ST_TOP,       // near full scale
		ST_WIDE,      // random width, every bit toggles
		ST_TYPICAL    // realistic frame times, 8 to 47 ms
	} sample_style_t;

	localparam int OPENING = 5;
	localparam logic [WSIZE_W-1:0] OPENING_SIZE [OPENING] = '{8'd1, 8'd128, 8'd255, 8'd0, 8'd2};
	localparam sample_style_t OPENING_STYLE [OPENING] =
		'{ST_ZERO, ST_TINY, ST_TOP, ST_WIDE, ST_TYPICAL};
	localparam logic [FRAME_TIME_W-1:0] EDGE_TIMES [8] = '{24'hFFFFFF, 24'h000000,
		24'h000001, 24'h800000, 24'h7FFFFF, 24'hAAAAAA, 24'h555555, 24'h001000};
	localparam logic [WSIZE_W-1:0] EDGE_SIZES [7] =
		'{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd129, 8'd255};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [WSIZE_W-1:0]      cfg_wr_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [FRAME_TIME_W-1:0] frame_time = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [RATE_W-1:0]       frame_rate;
	logic                    rate_updated;

	int mismatches, outstanding, reports, refreshes, saturated, zeroed;
	int sent = 0;
	int cfg_writes = 0;
	bit calm = 1'b0;          // no idling on either side once set
	bit holdoff_req = 1'b0;   // asks the receiver for its one long hold-off

	always #5 clk = ~clk;

	windowed_frame_rate_meter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_time   (frame_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_rate   (frame_rate),
		.rate_updated (rate_updated)
	);

	frame_rate_checker scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_time   (frame_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_rate   (frame_rate),
		.rate_updated (rate_updated),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.reports      (reports),
		.refreshes    (refreshes),
		.saturated    (saturated),
		.zeroed       (zeroed)
	);

	// Offer one frame time and hold it until the meter takes it. Called on a
	// rising edge; returns on the edge that accepted the request. A random
	// gap before the request lands on whatever the meter is doing then.
	task automatic send_frame(input logic [FRAME_TIME_W-1:0] ft);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		frame_time <= ft;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Drop valid and wait for every predicted report to come back. The first
	// edge lets the checker count a request taken on the calling edge.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Window size is only written with the meter idle; it also clears the window.
	task automatic write_window(input logic [WSIZE_W-1:0] size);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= size;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_writes++;
	endtask

	function automatic logic [FRAME_TIME_W-1:0] pick_time(sample_style_t style);
		case (style)
			ST_ZERO:    return '0;
			ST_TINY:    return FRAME_TIME_W'($urandom_range(0, 1));
			ST_TOP:     return 24'hFFFFFF - FRAME_TIME_W'($urandom_range(0, 15));
			ST_WIDE:    return FRAME_TIME_W'($urandom() >> $urandom_range(8, 31));
			default:    return FRAME_TIME_W'($urandom_range(2048, 12032));
		endcase
	endfunction

	// Receiver: stall bursts between open runs, one long
	// hold-off while the sender keeps offering, none in the calm tail.
	initial begin : receiver
		bit held_off;
		held_off = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (holdoff_req && !held_off) begin
				out_stall <= 1'b1;
				repeat (HOLDOFF) @(posedge clk);
				held_off = 1'b1;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Hang guard: well above the slowest legal run.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d reports pending", cycles, outstanding);
				$display("windowed_frame_rate_meter_top: mismatch");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int phase_idx;
		int phase_len;
		logic [WSIZE_W-1:0] size;
		sample_style_t style;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes under window zero (acts as one), an
		// oversize window (clamps to the ring depth) and the full ring.
		write_window(8'd0);
		foreach (EDGE_TIMES[i]) send_frame(EDGE_TIMES[i]);
		write_window(8'd255);
		foreach (EDGE_TIMES[i]) send_frame(EDGE_TIMES[i]);
		write_window(8'd128);
		foreach (EDGE_TIMES[i]) send_frame(EDGE_TIMES[i]);

		// Random phases: each rewrites the window size, then sends a run of
		// one content style. The opening phases pin the special cases: zero
		// sum, saturated rate, full-scale samples, one- and two-deep windows.
		phase_idx = 0;
		while (sent < TOTAL_ITEMS) begin
			if (phase_idx < OPENING) begin
				size = OPENING_SIZE[phase_idx];
				style = OPENING_STYLE[phase_idx];
			end else begin
				if ($urandom_range(0, 3) == 0)
					size = EDGE_SIZES[$urandom_range(0, 6)];
				else
					size = WSIZE_W'($urandom_range(1, 128));
				style = sample_style_t'($urandom_range(0, 4));
			end
			if (TOTAL_ITEMS - sent <= CALM_TAIL)
				calm = 1'b1;
			write_window(size);
			// hold-off starts once requests are flowing, so the input backs up
			if (phase_idx == OPENING + 1)
				holdoff_req = 1'b1;
			phase_len = $urandom_range(20, 90);
			if (phase_len > TOTAL_ITEMS - sent)
				phase_len = TOTAL_ITEMS - sent;
			repeat (phase_len) send_frame(pick_time(style));
			phase_idx++;
		end

		// Wait out every report, then a margin for anything stray.
		settle();
		repeat (DRAIN) @(posedge clk);

		$display("sent %0d frame times over %0d window writes; %0d reports checked",
			sent, cfg_writes, reports);
		$display("%0d rate recomputes, %0d saturated, %0d from a zero sum",
			refreshes, saturated, zeroed);
		if (mismatches == 0)
			$display("windowed_frame_rate_meter_top: match");
		else
			$display("windowed_frame_rate_meter_top: mismatch");
		$finish;
	end
endmodule
